/* design/qvr_pkg.sv */
// Shared constants for the quaternion vector rotator.
// Register map, default widths and the configuration port format.
// No dependencies.
package qvr_pkg;

  // Default parameter values
  localparam int VEC_WIDTH_DEF      = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Configuration port format
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes, in map order
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 4'd0,
    REG_QUAT_Y = 4'd1,
    REG_QUAT_Z = 4'd2,
    REG_QUAT_W = 4'd3
  } reg_idx_t;

endpackage

/* design/quaternion_vector_rotate.sv */
// Quaternion rotation of a vector stream: r = q * (v, 0) * conj(q).
// Four-stage pipeline: products, first rounding, products, second rounding and clamp.
// Depends on qvr_pkg.

// Usage
//   Configuration: write quat_x, quat_y, quat_z, quat_w (indexes 0 to 3, signed
//   Q1.QUAT_FRAC_BITS, 16 bits of cfg_data) with cfg_valid; cfg_ready is always
//   high. Writes to other indexes are ignored. Write only while no item is in flight.
//   Input channel: vec_valid / vec_stall with vec_x, vec_y, vec_z. An item is
//   taken on a clock edge where vec_valid is high and vec_stall low.
//   Output channel: rot_valid / rot_stall with rot_x, rot_y, rot_z and saturated.
//   Pipeline: four register stages, tracked by v1, v2, v3 and rot_valid in that
//   order; a result leaves on an edge where rot_valid is high and rot_stall low.
//   Throughput: one item per cycle unless vec_stall is high; each of the four
//   stages holds one item, and the stage boundaries after each multiply bank and
//   each rounding adder set the depth.
//   Stall: a stalled result holds in the output register; earlier stages keep
//   filling any empty slot, and vec_stall rises only once all four are full.
//   Reset (rst, synchronous): empties the pipeline and loads the identity
//   quaternion (w = 1.0, x = y = z = 0).
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]      cfg_data,
  // vector input channel
  input  logic                                vec_valid,
  output logic                                vec_stall,
  input  logic signed [VEC_WIDTH-1:0]         vec_x,
  input  logic signed [VEC_WIDTH-1:0]         vec_y,
  input  logic signed [VEC_WIDTH-1:0]         vec_z,
  // rotated result channel
  output logic                                rot_valid,
  input  logic                                rot_stall,
  output logic signed [VEC_WIDTH-1:0]         rot_x,
  output logic signed [VEC_WIDTH-1:0]         rot_y,
  output logic signed [VEC_WIDTH-1:0]         rot_z,
  output logic                                saturated
);
  import qvr_pkg::*;

  localparam int VW = VEC_WIDTH;
  localparam int F  = QUAT_FRAC_BITS;
  // quaternion width: 16 bits, or wider so the 1.0 reset value fits
  localparam int QW  = (F + 2 > CFG_DATA_W) ? F + 2 : CFG_DATA_W;
  localparam int PW1 = VW + QW;
  localparam int SW1 = (PW1 + 1 > F + 2) ? PW1 + 1 : F + 2;
  localparam int TW  = SW1 - F;
  localparam int PW2 = TW + QW;
  localparam int SW2 = (PW2 + 2 > F + 2) ? PW2 + 2 : F + 2;

  localparam logic signed [QW-1:0]  QUAT_ONE = QW'(1) << F;
  localparam logic signed [SW1-1:0] RND1     = SW1'(1) << (F - 1);
  localparam logic signed [SW2-1:0] RND2     = SW2'(1) << (F - 1);
  localparam logic signed [SW2-1:0] R_HI     = (SW2'(1) << (VW - 1)) - SW2'(1);
  localparam logic signed [SW2-1:0] R_LO     = -R_HI - SW2'(1);
  localparam logic signed [VW-1:0]  OUT_HI   = R_HI[VW-1:0];
  localparam logic signed [VW-1:0]  OUT_LO   = R_LO[VW-1:0];

  // round half up, then drop F fraction bits
  function automatic logic signed [TW-1:0] rnd_t(input logic signed [SW1-1:0] s);
    logic signed [SW1-1:0] y;
    logic signed [SW1-1:0] sh;
    y  = s + RND1;
    sh = y >>> F;
    return sh[TW-1:0];
  endfunction

  function automatic logic signed [SW2-1:0] rnd_r(input logic signed [SW2-1:0] s);
    logic signed [SW2-1:0] y;
    y = s + RND2;
    return y >>> F;
  endfunction

  // Configuration registers
  logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUAT_X: quat_x <= QW'($signed(cfg_data));
        REG_QUAT_Y: quat_y <= QW'($signed(cfg_data));
        REG_QUAT_Z: quat_z <= QW'($signed(cfg_data));
        REG_QUAT_W: quat_w <= QW'($signed(cfg_data));
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when its item moves on
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !rot_valid || !rot_stall;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign vec_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rot_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= vec_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) rot_valid <= v3;
    end
  end

  // Stage 1: q times each vector component
  logic signed [PW1-1:0] m_wvx, m_yvz, m_zvy;
  logic signed [PW1-1:0] m_wvy, m_xvz, m_zvx;
  logic signed [PW1-1:0] m_wvz, m_xvy, m_yvx;
  logic signed [PW1-1:0] m_xvx, m_yvy, m_zvz;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      m_wvx <= quat_w * vec_x;
      m_yvz <= quat_y * vec_z;
      m_zvy <= quat_z * vec_y;
      m_wvy <= quat_w * vec_y;
      m_xvz <= quat_x * vec_z;
      m_zvx <= quat_z * vec_x;
      m_wvz <= quat_w * vec_z;
      m_xvy <= quat_x * vec_y;
      m_yvx <= quat_y * vec_x;
      m_xvx <= quat_x * vec_x;
      m_yvy <= quat_y * vec_y;
      m_zvz <= quat_z * vec_z;
    end
  end

  // Stage 2: t = q * p, rounded back to integer units
  logic signed [TW-1:0] t_x, t_y, t_z, t_w;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      t_x <= rnd_t(SW1'(m_wvx) + SW1'(m_yvz) - SW1'(m_zvy));
      t_y <= rnd_t(SW1'(m_wvy) - SW1'(m_xvz) + SW1'(m_zvx));
      t_z <= rnd_t(SW1'(m_wvz) + SW1'(m_xvy) - SW1'(m_yvx));
      t_w <= rnd_t(-SW1'(m_xvx) - SW1'(m_yvy) - SW1'(m_zvz));
    end
  end

  // Stage 3: t times the conjugate's components
  logic signed [PW2-1:0] n_twx, n_twy, n_twz;
  logic signed [PW2-1:0] n_txw, n_txz, n_txy;
  logic signed [PW2-1:0] n_tyz, n_tyw, n_tyx;
  logic signed [PW2-1:0] n_tzy, n_tzx, n_tzw;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      n_twx <= t_w * quat_x;
      n_twy <= t_w * quat_y;
      n_twz <= t_w * quat_z;
      n_txw <= t_x * quat_w;
      n_txz <= t_x * quat_z;
      n_txy <= t_x * quat_y;
      n_tyz <= t_y * quat_z;
      n_tyw <= t_y * quat_w;
      n_tyx <= t_y * quat_x;
      n_tzy <= t_z * quat_y;
      n_tzx <= t_z * quat_x;
      n_tzw <= t_z * quat_w;
    end
  end

  // Stage 4: r = t * conj(q), rounded and clamped
  logic signed [SW2-1:0] r_x, r_y, r_z;
  logic                  clip_x, clip_y, clip_z;

  always_comb begin
    r_x = rnd_r(-SW2'(n_twx) + SW2'(n_txw) - SW2'(n_tyz) + SW2'(n_tzy));
    r_y = rnd_r(-SW2'(n_twy) + SW2'(n_txz) + SW2'(n_tyw) - SW2'(n_tzx));
    r_z = rnd_r(-SW2'(n_twz) - SW2'(n_txy) + SW2'(n_tyx) + SW2'(n_tzw));
    clip_x = (r_x > R_HI) || (r_x < R_LO);
    clip_y = (r_y > R_HI) || (r_y < R_LO);
    clip_z = (r_z > R_HI) || (r_z < R_LO);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      rot_x     <= (r_x > R_HI) ? OUT_HI : (r_x < R_LO) ? OUT_LO : r_x[VW-1:0];
      rot_y     <= (r_y > R_HI) ? OUT_HI : (r_y < R_LO) ? OUT_LO : r_y[VW-1:0];
      rot_z     <= (r_z > R_HI) ? OUT_HI : (r_z < R_LO) ? OUT_LO : r_z[VW-1:0];
      saturated <= clip_x || clip_y || clip_z;
    end
  end

`ifndef SYNTH
  // input is held off only when every stage is occupied and the output stalls
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> (v1 && v2 && v3 && rot_valid && rot_stall))
    else $error("vec_stall raised with a free pipeline slot");

  // a clipped result shows at least one component at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (rot_valid && saturated) |->
      (rot_x == OUT_HI || rot_x == OUT_LO || rot_y == OUT_HI ||
       rot_y == OUT_LO || rot_z == OUT_HI || rot_z == OUT_LO))
    else $error("saturated set without a clamped component");

  // reset leaves the identity rotation and an empty pipeline
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (quat_w == QUAT_ONE && quat_x == '0 && quat_y == '0 &&
                    quat_z == '0 && !v1 && !v2 && !v3 && !rot_valid))
    else $error("state after reset is not the identity with empty pipeline");
`endif

endmodule

/* test/tb_quaternion_vector_rotate.sv */
`timescale 1ns / 100ps
// Testbench for quaternion_vector_rotate: rotates vectors by q * (v, 0) * conj(q)
// and compares every result with an in-bench fixed-point predictor.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int VW         = VEC_WIDTH_DEF;
  localparam int FRAC       = QUAT_FRAC_BITS_DEF;
  localparam int PIPE_DEPTH = 4;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(REG_QUAT_W + 1);
  localparam logic [CFG_IDX_W-1:0] LAST_IDX = CFG_IDX_W'((1 << CFG_IDX_W) - 1);
  localparam longint ROT_MAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint ROT_MIN = -ROT_MAX - 1;
  localparam logic signed [15:0] Q_ONE = 16'sd1 <<< FRAC;

  typedef logic signed [VW-1:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  sat;
  } rotation_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic vec_valid;
  logic vec_stall;
  comp_t vec_x, vec_y, vec_z;
  logic rot_valid;
  logic rot_stall;
  comp_t rot_x, rot_y, rot_z;
  logic saturated;

  // quaternion as the bench believes it is loaded
  logic signed [15:0] quat_x_cur, quat_y_cur, quat_z_cur, quat_w_cur;

  rotation_t expected_rotations[$];
  int error_count;
  int vectors_sent;
  int rotations_seen;
  int saturated_seen;
  int quaternion_loads;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_length;
  int idle_cycles;

  quaternion_vector_rotate uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // round half up, then floor-shift away the fraction bits
  function automatic longint round_frac(input longint a);
    return (a + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic comp_t clip_comp(input longint a, inout logic sat);
    if (a > ROT_MAX) begin
      sat = 1'b1;
      return comp_t'(ROT_MAX);
    end
    if (a < ROT_MIN) begin
      sat = 1'b1;
      return comp_t'(ROT_MIN);
    end
    return comp_t'(a);
  endfunction

  // Predicted rotation of one vector by the current quaternion
  function automatic rotation_t rotate_vector(input comp_t vx, input comp_t vy,
                                              input comp_t vz);
    longint qx, qy, qz, qw, px, py, pz;
    longint tx, ty, tz, tw, rx, ry, rz;
    rotation_t res;
    logic sat;
    qx = quat_x_cur; qy = quat_y_cur; qz = quat_z_cur; qw = quat_w_cur;
    px = vx; py = vy; pz = vz;
    sat = 1'b0;
    // t = q * (v, 0)
    tx = round_frac(qw * px + qy * pz - qz * py);
    ty = round_frac(qw * py - qx * pz + qz * px);
    tz = round_frac(qw * pz + qx * py - qy * px);
    tw = round_frac(-(qx * px) - qy * py - qz * pz);
    // r = t * conj(q)
    rx = round_frac(-(tw * qx) + tx * qw - ty * qz + tz * qy);
    ry = round_frac(-(tw * qy) + tx * qz + ty * qw - tz * qx);
    rz = round_frac(-(tw * qz) - tx * qy + ty * qx + tz * qw);
    res.x = clip_comp(rx, sat);
    res.y = clip_comp(ry, sat);
    res.z = clip_comp(rz, sat);
    res.sat = sat;
    return res;
  endfunction

  // Offer one vector, with random idle cycles ahead of it
  task automatic send_vector(input comp_t vx, input comp_t vy, input comp_t vz);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      vec_valid <= 1'b0;
    end
    @(negedge clk);
    vec_valid <= 1'b1;
    vec_x <= vx;
    vec_y <= vy;
    vec_z <= vz;
    do @(posedge clk); while (vec_stall);
    expected_rotations.push_back(rotate_vector(vx, vy, vz));
    vectors_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_QUAT_X: quat_x_cur = data;
      REG_QUAT_Y: quat_y_cur = data;
      REG_QUAT_Z: quat_z_cur = data;
      REG_QUAT_W: quat_w_cur = data;
      default: ;
    endcase
  endtask

  // Drop valid, let the pipeline drain, then wait on with the input idle
  task automatic wait_idle();
    @(negedge clk);
    vec_valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic load_quaternion(input logic signed [15:0] qx, input logic signed [15:0] qy,
                                 input logic signed [15:0] qz, input logic signed [15:0] qw);
    wait_idle();
    write_reg(REG_QUAT_X, qx);
    write_reg(REG_QUAT_Y, qy);
    write_reg(REG_QUAT_Z, qz);
    write_reg(REG_QUAT_W, qw);
    @(negedge clk);
    cfg_valid <= 1'b0;
    quaternion_loads++;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    int holds_taken;
    hold_left = 0;
    holds_taken = 0;
    forever begin
      @(negedge clk);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left = hold_length;
      end
      if (hold_left > 0) begin
        hold_left--;
        rot_stall <= 1'b1;
      end else begin
        rot_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rotation_t want;
    if (rot_valid && !rot_stall) begin
      rotations_seen++;
      if (saturated) saturated_seen++;
      if (expected_rotations.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b",
                 $time, rot_x, rot_y, rot_z, saturated);
        error_count++;
      end else begin
        want = expected_rotations.pop_front();
        if (rot_x !== want.x) begin
          $display("%0t: rot_x expected %0d, got %0d", $time, want.x, rot_x);
          error_count++;
        end
        if (rot_y !== want.y) begin
          $display("%0t: rot_y expected %0d, got %0d", $time, want.y, rot_y);
          error_count++;
        end
        if (rot_z !== want.z) begin
          $display("%0t: rot_z expected %0d, got %0d", $time, want.z, rot_z);
          error_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %0b, got %0b", $time, want.sat, saturated);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (vec_valid && !vec_stall) || (rot_valid && !rot_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Identity quaternion straight out of reset, field extremes
  task automatic test_identity_after_reset();
    set_idling(0, 0);
    send_vector(16'sh7fff, 16'sh8000, 16'sd0);
    send_vector(16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(16'sd0, 16'sd0, 16'sd0);
    send_vector(16'sd1, -16'sd1, 16'sd1);
  endtask

  // Largest and most negative quaternions: heavy scaling, clipping on both rails
  task automatic test_extreme_quaternions();
    load_quaternion(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vector(16'sh7fff, 16'sh8000, 16'sd5);
    send_vector(16'sd3, 16'sd2, -16'sd1);
    load_quaternion(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_vector(16'sh8000, 16'sh7fff, 16'sh8000);
    send_vector(-16'sd2, 16'sd1, 16'sd0);
    // w = -2.0 scales by four
    load_quaternion(16'sd0, 16'sd0, 16'sd0, 16'sh8000);
    send_vector(16'sd8191, -16'sd8192, 16'sd8192);
    send_vector(16'sh7fff, 16'sh8000, 16'sd100);
    // quarter turn about z
    load_quaternion(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
    send_vector(16'sd1000, 16'sd0, 16'sd7);
    send_vector(16'sh7fff, 16'sh8000, 16'sh7fff);
  endtask

  // w = 0.5 halves odd values exactly onto the rounding tie
  task automatic test_rounding_half();
    load_quaternion(16'sd0, 16'sd0, 16'sd0, Q_ONE >>> 1);
    send_vector(16'sd1, -16'sd1, 16'sd3);
    send_vector(-16'sd3, 16'sd5, -16'sd7);
    load_quaternion(16'sd0, 16'sd0, 16'sd0, -(Q_ONE >>> 1));
    send_vector(16'sd1, -16'sd1, -16'sd5);
  endtask

  // Writes to indexes outside the map must leave the quaternion alone
  task automatic test_unused_index();
    load_quaternion(16'sd4096, -16'sd8192, 16'sd2048, 16'sd12000);
    wait_idle();
    write_reg(FIRST_UNUSED_IDX, 16'sh8000);
    write_reg(LAST_IDX, 16'sh7fff);
    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)), 16'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_vector(16'sd1234, -16'sd4321, 16'sd999);
    send_vector(16'sh8000, 16'sh7fff, 16'sd0);
  endtask

  // Long receiver hold-off while items keep coming, so the input side stalls
  task automatic test_backpressure_fill();
    load_quaternion(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
    set_idling(0, 0);
    hold_length = 60;
    hold_requests++;
    for (int i = 0; i < 30; i++) begin
      send_vector(comp_t'($urandom()), comp_t'($urandom()), comp_t'($urandom()));
    end
    set_idling(60, 60);
    hold_length = 40;
    hold_requests++;
    for (int i = 0; i < 20; i++) begin
      send_vector(comp_t'($urandom()), comp_t'($urandom()), comp_t'($urandom()));
    end
  endtask

  // Random streams over several quaternions and idling mixes
  task automatic test_random_streams();
    real parts[4];
    real norm;
    logic signed [15:0] qv[4];
    comp_t vx, vy, vz;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(60, 0);
        2: set_idling(0, 60);
        default: set_idling(29, 29);
      endcase
      if (phase % 2 == 0) begin
        // unit quaternion: a true rotation
        norm = 0.0;
        for (int i = 0; i < 4; i++) begin
          parts[i] = $itor($urandom_range(2000)) - 1000.0;
          norm += parts[i] * parts[i];
        end
        norm = $sqrt(norm);
        for (int i = 0; i < 4; i++) begin
          qv[i] = (norm < 1.0) ? ((i == 3) ? Q_ONE : 16'sd0) :
                  16'($rtoi(parts[i] / norm * $itor(Q_ONE)));
        end
      end else begin
        for (int i = 0; i < 4; i++) qv[i] = 16'($urandom());
      end
      load_quaternion(qv[0], qv[1], qv[2], qv[3]);
      for (int n = 0; n < 230; n++) begin
        if ($urandom_range(99) < 20) begin
          vx = comp_t'($signed($urandom_range(128)) - 64);
          vy = comp_t'($signed($urandom_range(128)) - 64);
          vz = comp_t'($signed($urandom_range(128)) - 64);
        end else begin
          vx = comp_t'($urandom());
          vy = comp_t'($urandom());
          vz = comp_t'($urandom());
        end
        send_vector(vx, vy, vz);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_QUAT_X;
    cfg_data = '0;
    vec_valid = 1'b0;
    vec_x = '0;
    vec_y = '0;
    vec_z = '0;
    rot_stall = 1'b0;
    quat_x_cur = 16'sd0;
    quat_y_cur = 16'sd0;
    quat_z_cur = 16'sd0;
    quat_w_cur = Q_ONE;
    error_count = 0;
    vectors_sent = 0;
    rotations_seen = 0;
    saturated_seen = 0;
    quaternion_loads = 0;
    hold_requests = 0;
    hold_length = 0;
    idle_cycles = 0;
    set_idling(0, 0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_identity_after_reset();
    test_extreme_quaternions();
    test_rounding_half();
    test_unused_index();
    test_backpressure_fill();
    test_random_streams();

    wait_idle();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (expected_rotations.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_rotations.size());
      error_count++;
    end
    $display("Rotated %0d vectors under %0d quaternion loads plus reset identity;",
             vectors_sent, quaternion_loads);
    $display("%0d results checked, %0d clipped, %0d errors.",
             rotations_seen, saturated_seen, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
